@@ rtl/text_line_splitter_top_defines.svh @@
// ---------------------------------------------------------------------------
// text line splitter assertion macros
// concurrent checks that vanish when SYNTHESIS is defined
// ---------------------------------------------------------------------------
`ifndef TEXT_LINE_SPLITTER_TOP_DEFINES_SVH
`define TEXT_LINE_SPLITTER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// prop must hold at every clock edge outside reset
`define TLS_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("tls assertion failed");
// expr must never be true outside reset
`define TLS_NEVER(name, clk, rst, expr) \
   name: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("tls forbidden condition seen");
`else
`define TLS_ASSERT(name, clk, rst, prop)
`define TLS_NEVER(name, clk, rst, expr)
`endif

`endif

@@ rtl/tls_pkg.sv @@
// ---------------------------------------------------------------------------
// text line splitter package
// byte codes, result width and the line beat passed between modules
// ---------------------------------------------------------------------------
package tls_pkg;

   localparam int DEFAULT_OFFSET_BITS = 32;
   localparam int RESULT_BITS         = 32;

   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_HASH  = 8'h23;

   typedef struct packed {
      logic                   valid;
      logic [RESULT_BITS-1:0] line_start;
      logic [RESULT_BITS-1:0] line_length;
   } tls_line_type;

endpackage

@@ rtl/text_line_splitter_top.sv @@
// ---------------------------------------------------------------------------
// text line splitter top level
// splits a byte stream into trimmed lines, reported as start and length
// ---------------------------------------------------------------------------
//  channel  direction  handshake            payload
//  req      in         req_valid/req_stall  req_text_byte, req_end_of_buffer
//  rsp      out        rsp_valid/rsp_stall  rsp_line_start, rsp_line_length
//  csr      in         csr_wr_en            csr_wr_data (comment lines enabled)
//
//  one byte per cycle while req_stall is low; a line beat is set by the
//  single scanner pass on its last byte, registered in the output register
//  synchronous reset clears all line state and enables comment skipping
//  a stalled rsp parks one beat in the skid entry; req_stall rises while
//  that entry is occupied and falls when the result register drains
// ---------------------------------------------------------------------------
module text_line_splitter_top
   import tls_pkg::*;
#(
   parameter int OFFSET_BITS = DEFAULT_OFFSET_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [7:0]             req_text_byte,
   input  logic                   req_end_of_buffer,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [RESULT_BITS-1:0] rsp_line_start,
   output logic [RESULT_BITS-1:0] rsp_line_length,
   input  logic                   csr_wr_en,
   input  logic                   csr_wr_data
);

   tls_line_type line_beat;
   logic         accept;
   logic         full;

   assign req_stall = full;
   assign accept    = req_valid && !full;

   tls_scanner #(
      .OFFSET_BITS (OFFSET_BITS)
   ) u_scanner (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .text_byte     (req_text_byte),
      .end_of_buffer (req_end_of_buffer),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .line_out      (line_beat)
   );

   tls_out_buffer u_out_buffer (
      .clock           (clock),
      .reset           (reset),
      .line_in         (line_beat),
      .full            (full),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_line_start  (rsp_line_start),
      .rsp_line_length (rsp_line_length)
   );

endmodule

@@ rtl/tls_scanner.sv @@
// ---------------------------------------------------------------------------
// text line splitter scanner
// per-byte line tracking, trimming and comment skip; emits one line beat
// ---------------------------------------------------------------------------
`include "text_line_splitter_top_defines.svh"

module tls_scanner
   import tls_pkg::*;
#(
   parameter int OFFSET_BITS = DEFAULT_OFFSET_BITS
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         accept,
   input  logic [7:0]   text_byte,
   input  logic         end_of_buffer,
   input  logic         csr_wr_en,
   input  logic         csr_wr_data,
   output tls_line_type line_out
);

   localparam logic [OFFSET_BITS-1:0] OFF_MAX = '1;

   logic [OFFSET_BITS-1:0] pos_ff, pos_in;
   logic [OFFSET_BITS-1:0] start_ff, start_in;
   logic [OFFSET_BITS-1:0] end_ff, end_in;
   logic                   in_line_ff, in_line_in;
   logic                   in_comment_ff, in_comment_in;
   logic                   comment_en_ff;

   logic                   space_or_tab;
   logic                   is_line_end;
   logic                   emit;
   logic [OFFSET_BITS-1:0] pos_next;
   logic [OFFSET_BITS-1:0] length;

   assign space_or_tab = (text_byte == CHAR_SPACE) || (text_byte == CHAR_TAB);
   assign is_line_end  = (text_byte == CHAR_CR) || (text_byte == CHAR_LF) ||
                         (text_byte == CHAR_NUL);
   // saturating increment of the current offset
   assign pos_next     = (pos_ff == OFF_MAX) ? OFF_MAX : pos_ff + 1'b1;

   always_comb begin
      start_in      = start_ff;
      end_in        = end_ff;
      in_line_in    = in_line_ff;
      in_comment_in = in_comment_ff;
      pos_in        = pos_ff;
      emit          = 1'b0;
      if (accept) begin
         if (in_comment_ff) begin
            if (is_line_end) begin
               in_comment_in = 1'b0;
            end
         end else if (in_line_ff) begin
            if (is_line_end) begin
               emit       = 1'b1;
               in_line_in = 1'b0;
            end else if (!space_or_tab) begin
               end_in = pos_next;
            end
         end else if (space_or_tab || is_line_end) begin
            // leading blanks and empty lines
         end else if (text_byte == CHAR_HASH && comment_en_ff) begin
            in_comment_in = 1'b1;
         end else begin
            in_line_in = 1'b1;
            start_in   = pos_ff;
            end_in     = pos_next;
         end
         if (end_of_buffer) begin
            if (in_line_in) begin
               emit = 1'b1;
            end
            in_line_in    = 1'b0;
            in_comment_in = 1'b0;
            pos_in        = '0;
         end else begin
            pos_in = pos_next;
         end
      end
   end

   assign length = (end_in <= start_in) ? OFFSET_BITS'(1) : end_in - start_in;

   assign line_out.valid       = emit;
   assign line_out.line_start  = RESULT_BITS'(start_in);
   assign line_out.line_length = RESULT_BITS'(length);

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff        <= '0;
         start_ff      <= '0;
         end_ff        <= '0;
         in_line_ff    <= 1'b0;
         in_comment_ff <= 1'b0;
         comment_en_ff <= 1'b1;
      end else begin
         pos_ff        <= pos_in;
         start_ff      <= start_in;
         end_ff        <= end_in;
         in_line_ff    <= in_line_in;
         in_comment_ff <= in_comment_in;
         if (csr_wr_en) begin
            comment_en_ff <= csr_wr_data;
         end
      end
   end

   `TLS_NEVER(a_line_and_comment, clock, reset, in_line_ff && in_comment_ff)
   `TLS_ASSERT(a_end_not_before_start, clock, reset, !in_line_ff || (end_ff >= start_ff))
   `TLS_ASSERT(a_pos_restarts, clock, reset, (accept && end_of_buffer) |=> (pos_ff == '0))

endmodule

@@ rtl/tls_out_buffer.sv @@
// ---------------------------------------------------------------------------
// text line splitter output buffer
// result register plus one skid entry between scanner and rsp channel
// ---------------------------------------------------------------------------
`include "text_line_splitter_top_defines.svh"

module tls_out_buffer
   import tls_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  tls_line_type           line_in,
   output logic                   full,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [RESULT_BITS-1:0] rsp_line_start,
   output logic [RESULT_BITS-1:0] rsp_line_length
);

   tls_line_type out_ff;
   tls_line_type skid_ff;
   logic         take;

   assign take = out_ff.valid && !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_ff.valid  <= 1'b0;
         skid_ff.valid <= 1'b0;
      end else begin
         if (!out_ff.valid || take) begin
            if (skid_ff.valid) begin
               out_ff        <= skid_ff;
               skid_ff.valid <= 1'b0;
            end else begin
               out_ff <= line_in;
            end
         end else if (line_in.valid) begin
            // result register still held, park the new beat
            skid_ff <= line_in;
         end
      end
   end

   assign full            = skid_ff.valid;
   assign rsp_valid       = out_ff.valid;
   assign rsp_line_start  = out_ff.line_start;
   assign rsp_line_length = out_ff.line_length;

   `TLS_ASSERT(a_skid_implies_out, clock, reset, !skid_ff.valid || out_ff.valid)
   `TLS_NEVER(a_no_push_when_full, clock, reset, line_in.valid && skid_ff.valid)
   `TLS_ASSERT(a_skid_drains, clock, reset, (skid_ff.valid && take) |=> !skid_ff.valid)

endmodule
